/* hw/rtl/tag_set_store_unit_assert.svh */
// assertion macros shared by the checker
`ifndef TAG_SET_STORE_UNIT_ASSERT_SVH
`define TAG_SET_STORE_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define TSS_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tag set store check failed");

// next-cycle implication, disabled while reset is held
`define TSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tag set store check failed");

`endif

/* hw/rtl/tss_pkg.sv */
package tss_pkg;

    localparam int ENTRIES     = 16;
    localparam int TAG_BITS    = 56;
    localparam int TAG_ID_BITS = 56;
    localparam int OP_BITS     = 2;
    localparam int OUT_CNT_BITS = 5;

    // compare width: the port never carries more than TAG_ID_BITS
    localparam int KEY_BITS = (TAG_BITS < TAG_ID_BITS) ? TAG_BITS : TAG_ID_BITS;

    localparam int CNT_RAW_BITS = $clog2(ENTRIES + 1);
    localparam int CNT_BITS = (CNT_RAW_BITS > OUT_CNT_BITS) ? CNT_RAW_BITS : OUT_CNT_BITS;

    localparam int S_TDATA_BITS = ((OP_BITS + TAG_ID_BITS + 7) / 8) * 8;
    localparam int M_FIELD_BITS = 1 + OUT_CNT_BITS + 1;
    localparam int M_TDATA_BITS = ((M_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_COMMIT
    } state_t;

    // search token walking down the cell row
    typedef struct packed {
        logic valid;
        logic hit;
        logic claimed;
    } token_t;

    // commit strobe broadcast to every cell
    typedef struct packed {
        logic insert;
        logic remove;
    } cmd_t;

endpackage

/* hw/rtl/tss_cell.sv */
module tss_cell
    import tss_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [KEY_BITS-1:0] key,
    input  token_t              tok_in,
    output token_t              tok_out,
    input  cmd_t                cmd
);

    logic                valid_reg;
    logic [KEY_BITS-1:0] tag_reg;
    logic                hit_mark_reg;
    logic                claim_mark_reg;
    token_t              tok_reg;
    token_t              tok_next;
    logic                match;
    logic                take;

    assign match = valid_reg && (tag_reg == key);
    // first free cell along the row claims the pending insert
    assign take  = !valid_reg && !tok_in.claimed;

    always_comb begin
        tok_next.valid   = tok_in.valid;
        tok_next.hit     = tok_in.hit | match;
        tok_next.claimed = tok_in.claimed | take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            hit_mark_reg   <= 1'b0;
            claim_mark_reg <= 1'b0;
            tok_reg        <= '0;
        end else begin
            tok_reg <= tok_next;
            if (tok_in.valid) begin
                hit_mark_reg   <= match;
                claim_mark_reg <= take;
            end
            if (cmd.insert && claim_mark_reg) begin
                valid_reg <= 1'b1;
            end else if (cmd.remove && hit_mark_reg) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert && claim_mark_reg) begin
            tag_reg <= key;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hw/rtl/tss_ctrl.sv */
module tss_ctrl
    import tss_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [OP_BITS-1:0]      opcode,
    input  logic [TAG_ID_BITS-1:0]  tag_id,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic                    was_present,
    output logic [OUT_CNT_BITS-1:0] entry_count,
    output logic                    full_drop,
    output logic [KEY_BITS-1:0]     key,
    output token_t                  tok_launch,
    input  token_t                  tok_done,
    output cmd_t                    cmd
);

    state_t                  state_reg, state_next;
    logic [OP_BITS-1:0]      op_reg;
    logic [KEY_BITS-1:0]     key_reg;
    token_t                  launch_reg, launch_next;
    logic                    hit_reg, claimed_reg;
    logic [CNT_BITS-1:0]     count_reg, count_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    was_present_reg;
    logic [OUT_CNT_BITS-1:0] count_out_reg;
    logic                    drop_reg;
    logic                    accept;
    logic                    out_free;
    logic                    fire;
    logic                    do_insert, do_remove, do_drop;

    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        fire       = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (tok_done.valid) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    fire       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        do_insert = 1'b0;
        do_remove = 1'b0;
        do_drop   = 1'b0;
        case (op_reg)
            OP_INSERT: begin
                do_insert = !hit_reg && claimed_reg;
                do_drop   = !hit_reg && !claimed_reg;
            end
            OP_REMOVE: begin
                do_remove = hit_reg;
            end
            OP_QUERY: begin
                do_insert = 1'b0;
            end
            default: begin
                // unused code behaves as a query
                do_insert = 1'b0;
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        if (fire && do_insert) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (fire && do_remove) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_comb begin
        launch_next         = '0;
        launch_next.valid   = accept;
        m_valid_next        = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            launch_reg  <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            launch_reg  <= launch_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg  <= opcode;
            key_reg <= tag_id[KEY_BITS-1:0];
        end
        if (tok_done.valid) begin
            hit_reg     <= tok_done.hit;
            claimed_reg <= tok_done.claimed;
        end
        if (fire) begin
            was_present_reg <= hit_reg;
            count_out_reg   <= count_next[OUT_CNT_BITS-1:0];
            drop_reg        <= do_drop;
        end
    end

    assign cmd.insert  = fire && do_insert;
    assign cmd.remove  = fire && do_remove;
    assign key         = key_reg;
    assign tok_launch  = launch_reg;
    assign m_tvalid    = m_valid_reg;
    assign was_present = was_present_reg;
    assign entry_count = count_out_reg;
    assign full_drop   = drop_reg;

endmodule

/* hw/rtl/tag_set_store_unit.sv */
// channel   dir  tdata fields (low bit first)                         tlast tuser
// s_        in   opcode[1:0], tag_id[57:2], zero pad [63:58]          -     -
// m_        out  was_present[0], entry_count[5:1], full_drop[6], pad  -     -
//
// one beat is in flight at a time; a search token walks the row of entry
// cells one cell per cycle, then the result is registered to m_tdata once the
// output register is free, and the next input beat is taken after that commit
// reset clears all valid bits and the count at once, no sweep
// a stalled result holds in the output register while the next search runs
module tag_set_store_unit
    import tss_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [S_TDATA_BITS-1:0] s_tdata,  // opcode, tag_id
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_TDATA_BITS-1:0] m_tdata   // was_present, entry_count, full_drop
);

    logic [KEY_BITS-1:0]     key;
    token_t                  tok [ENTRIES+1];
    cmd_t                    cmd;
    logic                    was_present;
    logic [OUT_CNT_BITS-1:0] entry_count;
    logic                    full_drop;

    tss_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .opcode      (s_tdata[OP_BITS-1:0]),
        .tag_id      (s_tdata[OP_BITS+TAG_ID_BITS-1:OP_BITS]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .was_present (was_present),
        .entry_count (entry_count),
        .full_drop   (full_drop),
        .key         (key),
        .tok_launch  (tok[0]),
        .tok_done    (tok[ENTRIES]),
        .cmd         (cmd)
    );

    for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
        tss_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .key     (key),
            .tok_in  (tok[i]),
            .tok_out (tok[i+1]),
            .cmd     (cmd)
        );
    end

    assign m_tdata = M_TDATA_BITS'({full_drop, entry_count, was_present});

endmodule

/* hw/rtl/tss_checker.sv */
`include "tag_set_store_unit_assert.svh"

module tss_checker
    import tss_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic [S_TDATA_BITS-1:0] s_tdata,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);

    logic count_in_range;
    logic count_is_full;

    assign count_in_range = (CNT_RAW_BITS > OUT_CNT_BITS) ||
                            (m_tdata[OUT_CNT_BITS:1] <= OUT_CNT_BITS'(ENTRIES));
    assign count_is_full  = m_tdata[OUT_CNT_BITS:1] == OUT_CNT_BITS'(ENTRIES);

    // stalled result holds
    `TSS_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    // one item at a time: no input beat right after one was taken
    `TSS_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // count never exceeds capacity
    `TSS_ASSERT_NOW(a_count_range, aclk, aresetn, m_tvalid, count_in_range)
    // a dropped insert means a new tag against a full store
    `TSS_ASSERT_NOW(a_drop_full, aclk, aresetn, m_tvalid && m_tdata[OUT_CNT_BITS+1],
                    !m_tdata[0] && count_is_full)

endmodule

bind tag_set_store_unit tss_checker u_checker (.*);
